// ===== sv/kwl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kwl_pkg;

  // Width of the internal source offset counter; it saturates at its maximum.
  localparam int unsigned POSITION_BITS = 16;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CW    = FIFO_AW + 1;

  localparam int unsigned WORD_MAX = 7;
  localparam int unsigned KW_COUNT = 10;

  // Token kinds
  localparam logic [4:0] KIND_DECLARE = 5'd0;
  localparam logic [4:0] KIND_ID      = 5'd10;
  localparam logic [4:0] KIND_NUMBER  = 5'd11;
  localparam logic [4:0] KIND_EQ      = 5'd12;
  localparam logic [4:0] KIND_ASSIGN  = 5'd13;
  localparam logic [4:0] KIND_PLUS    = 5'd14;
  localparam logic [4:0] KIND_MINUS   = 5'd15;
  localparam logic [4:0] KIND_STAR    = 5'd16;
  localparam logic [4:0] KIND_SLASH   = 5'd17;
  localparam logic [4:0] KIND_COMMA   = 5'd18;
  localparam logic [4:0] KIND_COLON   = 5'd19;
  localparam logic [4:0] KIND_SEMI    = 5'd20;
  localparam logic [4:0] KIND_LPAREN  = 5'd21;
  localparam logic [4:0] KIND_RPAREN  = 5'd22;
  localparam logic [4:0] KIND_LBRACE  = 5'd23;
  localparam logic [4:0] KIND_RBRACE  = 5'd24;
  localparam logic [4:0] KIND_EOF     = 5'd25;
  localparam logic [4:0] KIND_ERROR   = 5'd26;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUMBER,
    MODE_ASSIGN
  } mode_e;

  typedef struct packed {
    logic [4:0]  kind;
    logic [15:0] start;
    logic [15:0] len;
  } slot_t;

  // Everything one input item produces; the word text travels along so the
  // back end can resolve keywords on the first slot.
  typedef struct packed {
    logic                     two;
    slot_t                    s0;
    slot_t                    s1;
    logic [WORD_MAX-1:0][7:0] chars;
    logic [3:0]               count;
  } rec_t;

  function automatic logic [15:0] clip16(logic [POSITION_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/kwl_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kwl_front import kwl_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] ch_i,
  input  wire logic       end_of_source_i,
  output logic            push_o,
  output rec_t            rec_o,
  input  wire logic       full_i
);

  mode_e                    mode_q, mode_d;
  logic [WORD_MAX-1:0][7:0] chars_q, chars_d;
  logic [3:0]               count_q, count_d;
  logic [POSITION_BITS-1:0] begin_q, begin_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     halted_q, halted_d;

  logic  accept;
  logic  is_alpha, is_digit, is_space, is_ident;
  logic  sym_v;
  logic  [4:0] sym_k;
  logic  fl_cand_v, fl_v, fr_v;
  slot_t fl_cand, fl, fr;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign is_alpha = (ch_i inside {[8'h61:8'h7A], [8'h41:8'h5A]});
  assign is_digit = (ch_i inside {[8'h30:8'h39]});
  assign is_space = (ch_i inside {8'h20, [8'h09:8'h0D]});
  assign is_ident = is_alpha || is_digit || (ch_i == 8'h5F);

  always_comb begin
    sym_v = 1'b1;
    case (ch_i)
      8'h2B:   sym_k = KIND_PLUS;
      8'h2D:   sym_k = KIND_MINUS;
      8'h2A:   sym_k = KIND_STAR;
      8'h2F:   sym_k = KIND_SLASH;
      8'h2C:   sym_k = KIND_COMMA;
      8'h3A:   sym_k = KIND_COLON;
      8'h3B:   sym_k = KIND_SEMI;
      8'h28:   sym_k = KIND_LPAREN;
      8'h29:   sym_k = KIND_RPAREN;
      8'h7B:   sym_k = KIND_LBRACE;
      8'h7D:   sym_k = KIND_RBRACE;
      default: begin
        sym_v = 1'b0;
        sym_k = KIND_ERROR;
      end
    endcase
  end

  // Token that closes if the current byte does not extend it.
  always_comb begin
    fl_cand_v     = 1'b1;
    fl_cand.start = clip16(begin_q);
    fl_cand.len   = clip16(pos_q - begin_q);
    case (mode_q)
      MODE_WORD:   fl_cand.kind = KIND_ID;
      MODE_NUMBER: fl_cand.kind = KIND_NUMBER;
      MODE_ASSIGN: begin
        fl_cand.kind = KIND_ASSIGN;
        fl_cand.len  = 16'd1;
      end
      default: begin
        fl_cand_v    = 1'b0;
        fl_cand.kind = KIND_ID;
      end
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    chars_d  = chars_q;
    count_d  = count_q;
    begin_d  = begin_q;
    pos_d    = pos_q;
    halted_d = halted_q;
    fl_v     = 1'b0;
    fl       = fl_cand;
    fr_v     = 1'b0;
    fr       = '{kind: KIND_EOF, start: clip16(pos_q), len: 16'd0};

    if (accept) begin
      if (end_of_source_i) begin
        if (!halted_q) begin
          fl_v = fl_cand_v;
          fr_v = 1'b1;
        end
        // back to the start of a fresh text
        mode_d   = MODE_IDLE;
        count_d  = '0;
        begin_d  = '0;
        pos_d    = '0;
        halted_d = 1'b0;
      end else if (!halted_q) begin
        if (mode_q == MODE_WORD && is_ident) begin
          if (count_q < 4'(WORD_MAX)) chars_d[count_q[2:0]] = ch_i;
          if (count_q <= 4'(WORD_MAX)) count_d = count_q + 4'd1;
        end else if (mode_q == MODE_NUMBER && is_digit) begin
          mode_d = MODE_NUMBER;
        end else if (mode_q == MODE_ASSIGN && ch_i == 8'h3D) begin
          fr_v   = 1'b1;
          fr     = '{kind: KIND_EQ, start: clip16(begin_q), len: 16'd2};
          mode_d = MODE_IDLE;
        end else begin
          fl_v   = fl_cand_v;
          mode_d = MODE_IDLE;
          if (is_space) begin
            mode_d = MODE_IDLE;
          end else if (is_alpha || ch_i == 8'h5F) begin
            mode_d     = MODE_WORD;
            begin_d    = pos_q;
            chars_d[0] = ch_i;
            count_d    = 4'd1;
          end else if (is_digit) begin
            mode_d  = MODE_NUMBER;
            begin_d = pos_q;
          end else if (ch_i == 8'h3D) begin
            mode_d  = MODE_ASSIGN;
            begin_d = pos_q;
          end else if (sym_v) begin
            fr_v = 1'b1;
            fr   = '{kind: sym_k, start: clip16(pos_q), len: 16'd1};
          end else begin
            // unknown byte: report and ignore the rest of the text
            fr_v     = 1'b1;
            fr       = '{kind: KIND_ERROR, start: clip16(pos_q), len: 16'd1};
            halted_d = 1'b1;
          end
        end
        if (pos_q != POS_MAX) pos_d = pos_q + 1'b1;
      end
    end
  end

  assign push_o      = accept && (fl_v || fr_v);
  assign rec_o.two   = fl_v && fr_v;
  assign rec_o.s0    = fl_v ? fl : fr;
  assign rec_o.s1    = fr;
  assign rec_o.chars = chars_q;
  assign rec_o.count = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      count_q  <= '0;
      begin_q  <= '0;
      pos_q    <= '0;
      halted_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      count_q  <= count_d;
      begin_q  <= begin_d;
      pos_q    <= pos_d;
      halted_q <= halted_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chars_q <= chars_d;
  end

endmodule

`default_nettype wire

// ===== sv/kwl_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kwl_fifo import kwl_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire rec_t wr_data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output rec_t      rd_data_o,
  output logic      empty_o
);

  rec_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] cnt_q;

  assign full_o    = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wr_data_i;
  end

  // depth is a power of two, so the pointers wrap on their own
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i) rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/kwl_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kwl_back import kwl_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire rec_t   rec_i,
  input  wire logic   empty_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output logic [4:0]  kind_o,
  output logic [15:0] start_res_o,
  output logic [15:0] length_o,
  output logic        last_o
);

  function automatic logic [55:0] kw_text(int unsigned k);
    case (k)
      0:       return "declare";
      1:       return {"int", 32'h0};
      2:       return {"void", 24'h0};
      3:       return {"if", 40'h0};
      4:       return {"else", 24'h0};
      5:       return {"while", 16'h0};
      6:       return {"print", 16'h0};
      7:       return {"class", 16'h0};
      8:       return {"method", 8'h0};
      default: return {"return", 8'h0};
    endcase
  endfunction

  function automatic logic [3:0] kw_len(int unsigned k);
    case (k)
      0:       return 4'd7;
      1:       return 4'd3;
      2, 4:    return 4'd4;
      3:       return 4'd2;
      5, 6, 7: return 4'd5;
      default: return 4'd6;
    endcase
  endfunction

  // Compare the held word against all keywords at once.
  function automatic logic [4:0] word_kind(logic [WORD_MAX-1:0][7:0] chars,
                                           logic [3:0] count);
    logic [4:0]  res;
    logic        hit;
    logic [55:0] txt;
    res = KIND_ID;
    for (int unsigned k = 0; k < KW_COUNT; k++) begin
      txt = kw_text(k);
      hit = (count == kw_len(k));
      for (int unsigned i = 0; i < WORD_MAX; i++) begin
        if (4'(i) < count && chars[i] != txt[55-8*i -: 8]) hit = 1'b0;
      end
      if (hit) res = KIND_DECLARE + 5'(k);
    end
    return res;
  endfunction

  logic  out_v_q, sec_v_q, last_q;
  slot_t out_q, sec_q;
  logic  load;
  slot_t head;

  assign load  = !out_v_q || out_ready_i;
  assign pop_o = load && !sec_v_q && !empty_i;

  always_comb begin
    head = rec_i.s0;
    if (rec_i.s0.kind == KIND_ID) head.kind = word_kind(rec_i.chars, rec_i.count);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sec_v_q <= 1'b0;
    end else if (load) begin
      if (sec_v_q) begin
        out_v_q <= 1'b1;
        sec_v_q <= 1'b0;
      end else if (!empty_i) begin
        out_v_q <= 1'b1;
        sec_v_q <= rec_i.two;
      end else begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (sec_v_q) begin
        out_q  <= sec_q;
        last_q <= 1'b1;
      end else if (!empty_i) begin
        out_q  <= head;
        last_q <= !rec_i.two;
        sec_q  <= rec_i.s1;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign kind_o      = out_q.kind;
  assign start_res_o = out_q.start;
  assign length_o    = out_q.len;
  assign last_o      = last_q;

endmodule

`default_nettype wire

// ===== sv/keyword_lexer_tokenizer_unit.sv =====
// Channel  Handshake                 Payload
// in       in_valid_i / in_ready_o   ch_i[7:0], end_of_source_i
// out      out_valid_o / out_ready_i kind_o[4:0], start_res_o[15:0], length_o[15:0], last_o
//
// One source byte is taken every cycle while the queue has room; keyword resolution
// happens after the queue. An item that yields two tokens holds the output until both
// are out; the output drains one token per cycle while out_ready_i is high, and the
// four-entry record queue absorbs the difference. Input stalls only when that queue is
// full. Reset needs no clearing pass; the block takes items as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module keyword_lexer_tokenizer_unit import kwl_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  ch_i,
  input  wire logic        end_of_source_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [4:0]       kind_o,
  output logic [15:0]      start_res_o,
  output logic [15:0]      length_o,
  output logic             last_o
);

  logic push, pop, full, empty;
  rec_t wr_rec, rd_rec;

  kwl_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .ch_i            (ch_i),
    .end_of_source_i (end_of_source_i),
    .push_o          (push),
    .rec_o           (wr_rec),
    .full_i          (full)
  );

  kwl_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i (wr_rec),
    .full_o    (full),
    .pop_i     (pop),
    .rd_data_o (rd_rec),
    .empty_o   (empty)
  );

  kwl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (rd_rec),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .start_res_o (start_res_o),
    .length_o    (length_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// ===== sv/kwl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kwl_checker import kwl_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [4:0]  kind_o,
  input wire logic [15:0] start_res_o,
  input wire logic [15:0] length_o,
  input wire logic        last_o
);

  // hold a stalled token
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o)
      && $stable(start_res_o) && $stable(length_o) && $stable(last_o))
    else $error("stalled token changed");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> kind_o <= KIND_ERROR)
    else $error("token kind out of range");

  a_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_EOF |-> length_o == 16'd0 && last_o)
    else $error("end-of-file token malformed");

  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_ERROR || kind_o == KIND_PLUS || kind_o == KIND_RBRACE)
      |-> length_o == 16'd1 && last_o)
    else $error("single-byte token malformed");

endmodule

bind keyword_lexer_tokenizer_unit kwl_checker u_kwl_checker (.*);

`default_nettype wire
